>>> rtl/alm_pkg.sv
// Shared types and codes for the array linked list manager.
package alm_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH_HEAD = 3'd0;
  localparam logic [2:0] REQ_PUSH_TAIL = 3'd1;
  localparam logic [2:0] REQ_INSERT    = 3'd2;
  localparam logic [2:0] REQ_REMOVE    = 3'd3;
  localparam logic [2:0] REQ_FIND      = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD1,
    S_EXEC,
    S_WR_A,
    S_WR_B,
    S_WALK,
    S_DONE
  } alm_state_t;

endpackage

>>> rtl/array_linked_list_manager.sv
// Top level: array doubly linked list with free list, request sequencer.
//
//  channel | dir | tdata bits (low first)                         | tuser
//  s_axis  | in  | req_type[2:0], item_value[66:3], position[72:67] | -
//  m_axis  | out | status[1:0], entry_index[7:2], live_count[13:8] | -
//
// Push, insert and remove step through RD1, EXEC, WR_A, WR_B and DONE after the item
// is accepted, a rejected request through RD1, EXEC and DONE; the next item is taken in IDLE.
// Find of rank k walks one next link a cycle in WALK before DONE.
// After reset a clearing pass over all ENTRIES entries builds the free chain and
// clears the occupied bits; no item is accepted during it.
// One item is in work at a time; a held result only stalls the next item at its end.
module array_linked_list_manager
  import alm_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // req_type, item_value, position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status, entry_index, live_count
);

  localparam int AW = $clog2(ENTRIES);

  alm_state_t state, state_next;

  logic [2:0]    req;
  logic [63:0]   val;
  logic [5:0]    pos;
  logic [AW-1:0] p_idx;
  logic          p_ok;
  logic [AW-1:0] head, tail, fhead, cnt;
  logic [AW-1:0] cur, idx, nxt_r, prv_r;
  logic [5:0]    rank;
  logic [1:0]    st;
  logic [1:0]    st_rd1, st_chk;
  logic [AW-1:0] ridx;
  logic [AW:0]   init_cnt;
  logic          out_free;

  // Memories for values and occupied bits
  logic [63:0]   vmem [ENTRIES];
  logic          occ  [ENTRIES];
  logic          occ_rd;

  // Link memory ports
  logic          nw_en, pw_en;
  logic [AW-1:0] nw_addr, nw_data, pw_addr, pw_data;
  logic [AW-1:0] nr_addr, pr_addr, nr_data, pr_data;

  alm_link_mem #(.AW(AW)) u_next (
    .clk(clk), .wr_addr(nw_addr), .wr_en(nw_en), .wr_data(nw_data),
    .rd_addr(nr_addr), .rd_data(nr_data));
  alm_link_mem #(.AW(AW)) u_prev (
    .clk(clk), .wr_addr(pw_addr), .wr_en(pw_en), .wr_data(pw_data),
    .rd_addr(pr_addr), .rd_data(pr_data));

  assign s_axis_tready = (state == S_IDLE);
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  // Result register can take a new item
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Position in range and nonzero
  always_comb begin
    p_idx = AW'(pos);
    p_ok  = (pos != 6'd0) && ({26'd0, pos} < 32'(ENTRIES));
  end

  // First classification: request code, position range, empty list for find
  always_comb begin
    st_rd1 = ST_OK;
    if (req == REQ_FIND) begin
      if (pos == 6'd0 || head == '0) st_rd1 = ST_BAD;
    end else if (req == REQ_INSERT || req == REQ_REMOVE) begin
      if (!p_ok) st_rd1 = ST_BAD;
    end else if (req != REQ_PUSH_HEAD && req != REQ_PUSH_TAIL) begin
      st_rd1 = ST_BAD;
    end
  end

  // Second classification: occupied entry, then fullness
  always_comb begin
    st_chk = st;
    if (st == ST_OK && (req == REQ_INSERT || req == REQ_REMOVE) && !occ_rd) begin
      st_chk = ST_BAD;
    end else if (st == ST_OK && req != REQ_REMOVE && req != REQ_FIND && fhead == '0) begin
      st_chk = ST_FULL;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (init_cnt == (AW+1)'(ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE: if (acc) state_next = S_RD1;
      S_RD1:  state_next = S_EXEC;
      S_EXEC: begin
        if (st_chk != ST_OK) state_next = S_DONE;
        else if (req == REQ_FIND) state_next = S_WALK;
        else state_next = S_WR_A;
      end
      S_WR_A: state_next = S_WR_B;
      S_WR_B: state_next = S_DONE;
      S_WALK: if (rank <= 6'd1 || cur == '0) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Read address select: position for remove and insert, head for find, link chain in walk, free head else
  always_comb begin
    nr_addr = fhead;
    pr_addr = p_idx;
    if (state == S_IDLE) begin
      nr_addr = (s_axis_tdata[2:0] == REQ_FIND) ? head : fhead;
      if (s_axis_tdata[2:0] == REQ_INSERT || s_axis_tdata[2:0] == REQ_REMOVE) begin
        nr_addr = AW'(s_axis_tdata[72:67]);
      end
      pr_addr = AW'(s_axis_tdata[72:67]);
    end else if (state == S_EXEC) begin
      nr_addr = (req == REQ_FIND) ? head : fhead;
    end else if (state == S_WALK) begin
      nr_addr = nr_data;
    end
  end

  // Link writes per state
  always_comb begin
    nw_en = 1'b0; nw_addr = '0; nw_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0;
    unique case (state)
      S_INIT: begin
        nw_en = 1'b1; nw_addr = init_cnt[AW-1:0];
        nw_data = (init_cnt == '0 || init_cnt == (AW+1)'(ENTRIES - 1)) ? '0
                  : AW'(init_cnt + 1'b1);
        pw_en = 1'b1; pw_addr = init_cnt[AW-1:0];
      end
      S_WR_A: begin
        unique case (req)
          REQ_PUSH_HEAD: begin
            nw_en = 1'b1; nw_addr = idx; nw_data = head;
            pw_en = 1'b1; pw_addr = idx; pw_data = '0;
          end
          REQ_PUSH_TAIL: begin
            nw_en = 1'b1; nw_addr = idx; nw_data = '0;
            pw_en = 1'b1; pw_addr = idx; pw_data = tail;
          end
          REQ_INSERT: begin
            nw_en = 1'b1; nw_addr = idx; nw_data = nxt_r;
            pw_en = 1'b1; pw_addr = idx; pw_data = ridx;
          end
          default: begin
            // remove: unlink neighbours
            nw_en = (prv_r != '0); nw_addr = prv_r; nw_data = nxt_r;
            pw_en = (nxt_r != '0); pw_addr = nxt_r; pw_data = prv_r;
          end
        endcase
      end
      S_WR_B: begin
        unique case (req)
          REQ_PUSH_HEAD: begin
            pw_en = (head != '0); pw_addr = head; pw_data = idx;
          end
          REQ_PUSH_TAIL: begin
            nw_en = (tail != '0); nw_addr = tail; nw_data = idx;
          end
          REQ_INSERT: begin
            nw_en = 1'b1; nw_addr = ridx; nw_data = idx;
            pw_en = (nxt_r != '0); pw_addr = nxt_r; pw_data = idx;
          end
          default: begin
            nw_en = 1'b1; nw_addr = ridx; nw_data = fhead;
            pw_en = 1'b1; pw_addr = ridx; pw_data = '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Value store and occupied bits
  always_ff @(posedge clk) begin
    if (state == S_INIT) occ[init_cnt[AW-1:0]] <= 1'b0;
    if (state == S_WR_A && req != REQ_REMOVE) begin
      occ[idx] <= 1'b1;
      vmem[idx] <= val;
    end
    if (state == S_WR_B && req == REQ_REMOVE) occ[ridx] <= 1'b0;
    occ_rd <= occ[pr_addr];
  end

  // Control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_cnt <= '0;
      head <= '0; tail <= '0; fhead <= AW'(1); cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) init_cnt <= init_cnt + 1'b1;
      if (state == S_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (acc) begin
        req <= s_axis_tdata[2:0]; val <= s_axis_tdata[66:3];
        pos <= s_axis_tdata[72:67];
      end
      if (state == S_RD1) begin
        ridx <= p_idx; nxt_r <= nr_data; prv_r <= pr_data;
        cur <= head; rank <= pos;
        st <= st_rd1; idx <= fhead;
      end
      if (state == S_EXEC) begin
        st <= st_chk;
        if (st_chk == ST_OK && req == REQ_INSERT && ridx == tail) req <= REQ_PUSH_TAIL;
        if (req == REQ_FIND) cur <= head;
      end
      if (state == S_WR_A && req != REQ_REMOVE) begin
        fhead <= nr_data; cnt <= cnt + 1'b1;
      end
      if (state == S_WR_B) begin
        unique case (req)
          REQ_PUSH_HEAD: begin
            if (head == '0) tail <= idx;
            head <= idx;
          end
          REQ_PUSH_TAIL: begin
            if (tail == '0) head <= idx;
            tail <= idx;
          end
          REQ_INSERT: if (nxt_r == '0) tail <= idx;
          default: begin
            if (prv_r == '0) head <= nxt_r;
            if (nxt_r == '0) tail <= prv_r;
            fhead <= ridx; cnt <= cnt - 1'b1; idx <= ridx;
          end
        endcase
      end
      if (state == S_WALK) begin
        if (rank > 6'd1 && cur != '0) begin
          cur <= nr_data; rank <= rank - 1'b1;
        end
      end
    end
  end

  // Result register
  logic [AW-1:0] res_idx;
  always_comb begin
    res_idx = (req == REQ_FIND) ? cur : idx;
    if (st != ST_OK || (req == REQ_FIND && cur == '0)) res_idx = '0;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata[1:0]  <= (req == REQ_FIND && cur == '0) ? ST_BAD : st;
      m_axis_tdata[7:2]  <= 6'(res_idx);
      m_axis_tdata[13:8] <= 6'(cnt);
      m_axis_tdata[15:14] <= 2'b00;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cnt} < (AW+1)'(ENTRIES))) else $error("count overflow");
  a_empty_links: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cnt == '0) |-> (head == '0 && tail == '0))
    else $error("empty list with links");
`endif

endmodule

>>> rtl/alm_link_mem.sv
// Link memory: one synchronous write port, one registered read port.
module alm_link_mem
  import alm_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [2**AW];

  // Write and registered read; a read of the written address returns the old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
